### hdl/lsra_pkg.sv
package lsra_pkg;

  localparam int REG_CNT_W    = 6;
  localparam int MASK_W       = 32;
  localparam int PHYS_LIMIT   = 32;
  localparam int DEF_MAX_REGS = 32;
  localparam int VID_W        = 16;
  localparam int POS_W        = 16;
  localparam int PHYS_W       = 5;
  localparam int CNT_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CNT_W-1:0]     CNT_MAX           = '1;
  localparam logic [REG_CNT_W-1:0] REG_COUNT_DEFAULT = REG_CNT_W'(16);
  localparam logic [MASK_W-1:0]    RES_MASK_DEFAULT  = MASK_W'(48);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REG_COUNT = 1'b0,
    CFG_RES_MASK  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             new_run;
    logic [VID_W-1:0] virtual_id;
    logic [POS_W-1:0] live_start;
    logic [POS_W-1:0] live_end;
  } in_item_t;

  typedef struct packed {
    logic [VID_W-1:0]  virtual_out;
    logic [PHYS_W-1:0] physical_out;
    logic              was_spilled;
    logic [CNT_W-1:0]  slot_out;
    logic [CNT_W-1:0]  spill_total;
  } out_item_t;

  typedef struct packed {
    logic                 go;
    logic                 clear;
    logic [POS_W-1:0]     live_start;
    logic [REG_CNT_W-1:0] limit;
    logic [MASK_W-1:0]    reserved;
  } walk_ctrl_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [PHYS_W-1:0] phys;
  } walk_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

### hdl/linear_scan_register_allocator.sv
// Channel  Ports                         Dir  Transaction
// in       in_valid in_stall in_data     in   one live interval
// out      out_valid out_stall out_data  out  one allocation result
// cfg      cfg_we cfg_index cfg_wdata    in   register write, no read-back
//
// The end-position memory, min(MAX_REGS,32) entries deep, is read one entry per cycle
// by a single comparator that does expiry and free search in the same pass; the walk
// then ends in a finish state that commits the result, and no new interval is
// taken before that commit.
// Reset is synchronous, active low; the end store is not cleared.
// The result waits in an output register under out_stall; the next interval
// is taken meanwhile, and commit holds until the output register frees.
module linear_scan_register_allocator import lsra_pkg::*; #(
  parameter int MAX_REGS = DEF_MAX_REGS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int NREGS = (MAX_REGS < PHYS_LIMIT) ? MAX_REGS : PHYS_LIMIT;
  localparam int IDX_W = $clog2(NREGS);
  localparam logic [REG_CNT_W-1:0] NREGS_C = REG_CNT_W'(NREGS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [REG_CNT_W-1:0] reg_count_r;
  logic [MASK_W-1:0]    res_mask_r;
  in_item_t             item_r;
  logic [CNT_W-1:0]     next_slot_r;
  logic [CNT_W-1:0]     spill_cnt_r;
  logic                 out_valid_r;
  out_item_t            out_r;
  logic                 in_acc;
  logic                 commit;
  logic                 mem_we;
  logic [IDX_W-1:0]     rd_addr;
  logic [POS_W-1:0]     rd_data;
  walk_ctrl_t           ctrl;
  walk_stat_t           stat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign commit    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign mem_we    = commit && stat.found;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    ctrl.go         = in_acc;
    ctrl.clear      = in_data.new_run;
    ctrl.live_start = item_r.live_start;
    ctrl.limit      = (reg_count_r < NREGS_C) ? reg_count_r : NREGS_C;
    ctrl.reserved   = res_mask_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_WALK;
      ST_WALK: if (stat.done) state_nxt = ST_FIN;
      ST_FIN:  if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_count_r <= REG_COUNT_DEFAULT;
      res_mask_r  <= RES_MASK_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_REG_COUNT: reg_count_r <= cfg_wdata[REG_CNT_W-1:0];
        CFG_RES_MASK:  res_mask_r  <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_slot_r <= '0;
      spill_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && in_data.new_run) begin
        next_slot_r <= '0;
        spill_cnt_r <= '0;
      end else if (commit && !stat.found) begin
        next_slot_r <= sat_inc(next_slot_r);
        spill_cnt_r <= sat_inc(spill_cnt_r);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r.virtual_out <= item_r.virtual_id;
      if (stat.found) begin
        out_r.physical_out <= stat.phys;
        out_r.was_spilled  <= 1'b0;
        out_r.slot_out     <= '0;
        out_r.spill_total  <= spill_cnt_r;
      end else begin
        out_r.physical_out <= '0;
        out_r.was_spilled  <= 1'b1;
        out_r.slot_out     <= next_slot_r;
        out_r.spill_total  <= sat_inc(spill_cnt_r);
      end
    end
  end

  lsra_walk #(
    .NREGS (NREGS)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (stat)
  );

  lsra_end_mem #(
    .DEPTH (NREGS)
  ) u_end_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IDX_W'(stat.phys)),
    .wdata (item_r.live_end),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

### hdl/lsra_end_mem.sv
module lsra_end_mem import lsra_pkg::*; #(
  parameter int DEPTH = PHYS_LIMIT,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [POS_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [POS_W-1:0]  rdata
);

  logic [POS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/lsra_walk.sv
module lsra_walk import lsra_pkg::*; #(
  parameter int NREGS = PHYS_LIMIT,
  localparam int IDX_W = $clog2(NREGS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  walk_ctrl_t       ctrl,
  output logic [IDX_W-1:0] rd_addr,
  input  logic [POS_W-1:0] rd_data,
  output walk_stat_t       stat
);

  localparam logic [IDX_W:0]   CNT_END  = (IDX_W+1)'(NREGS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NREGS - 1);

  logic             busy_r;
  logic [IDX_W:0]   rd_cnt_r;
  logic             pipe_vld_r;
  logic [IDX_W-1:0] pipe_idx_r;
  logic [NREGS-1:0] map_r;
  logic             found_r;
  logic [IDX_W-1:0] phys_r;
  logic             done_r;
  logic             alive;
  logic             avail;

  // entry stays allocated unless its end is strictly below the new start
  always_comb begin
    alive = map_r[pipe_idx_r] && !(rd_data < ctrl.live_start);
    avail = !alive && !ctrl.reserved[pipe_idx_r] &&
            (REG_CNT_W'(pipe_idx_r) < ctrl.limit) && !found_r;
  end

  assign rd_addr = rd_cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      rd_cnt_r   <= '0;
      pipe_vld_r <= 1'b0;
      map_r      <= '0;
      found_r    <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.go) begin
        busy_r     <= 1'b1;
        rd_cnt_r   <= '0;
        pipe_vld_r <= 1'b0;
        found_r    <= 1'b0;
        if (ctrl.clear) begin
          map_r <= '0;
        end
      end else if (busy_r) begin
        if (rd_cnt_r < CNT_END) begin
          pipe_vld_r <= 1'b1;
          pipe_idx_r <= rd_cnt_r[IDX_W-1:0];
          rd_cnt_r   <= rd_cnt_r + (IDX_W+1)'(1);
        end else begin
          pipe_vld_r <= 1'b0;
        end
        if (pipe_vld_r) begin
          map_r[pipe_idx_r] <= alive || avail;
          if (avail) begin
            found_r <= 1'b1;
            phys_r  <= pipe_idx_r;
          end
          if (pipe_idx_r == LAST_IDX) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    stat.done  = done_r;
    stat.found = found_r;
    stat.phys  = PHYS_W'(phys_r);
  end

endmodule

### hdl/lsra_checker.sv
module lsra_checker import lsra_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // one interval at a time: stall rises after an accept and holds into the walk
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken during walk");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_spill_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_spilled |->
      out_data.physical_out == '0 && out_data.spill_total != '0)
    else $error("bad spill result");

  a_alloc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.was_spilled |-> out_data.slot_out == '0)
    else $error("slot on allocated result");

endmodule

bind linear_scan_register_allocator lsra_checker u_lsra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/allocation_checker.sv
`timescale 1ns / 100ps

module allocation_checker import lsra_pkg::*; #(
  parameter int MAX_REGS = DEF_MAX_REGS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    spilled
);

  logic [REG_CNT_W-1:0]  reg_count;
  logic [MASK_W-1:0]     res_mask;
  logic [PHYS_LIMIT-1:0] busy_map;
  logic [POS_W-1:0]      end_pos [PHYS_LIMIT];
  logic [CNT_W-1:0]      slot_next;
  logic [CNT_W-1:0]      spill_cnt;
  out_item_t             grant_q [$];
  int                    n_bad = 0;
  int                    n_checked = 0;
  int                    n_spilled = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    spilled    = 0;
  end

  function automatic out_item_t allocate_interval(input in_item_t iv);
    out_item_t         r;
    int                i;
    int                lim;
    bit                hit;
    logic [PHYS_W-1:0] pick;
    r    = '0;
    hit  = 1'b0;
    pick = '0;
    if (iv.new_run) begin
      busy_map  = '0;
      slot_next = '0;
      spill_cnt = '0;
    end
    for (i = 0; i < PHYS_LIMIT; i++)
      if (busy_map[i] && end_pos[i] < iv.live_start) busy_map[i] = 1'b0;
    lim = int'(reg_count);
    if (lim > MAX_REGS) lim = MAX_REGS;
    if (lim > PHYS_LIMIT) lim = PHYS_LIMIT;
    for (i = 0; i < lim; i++)
      if (!hit && !busy_map[i] && !res_mask[i]) begin
        hit  = 1'b1;
        pick = PHYS_W'(i);
      end
    r.virtual_out = iv.virtual_id;
    if (hit) begin
      busy_map[pick]  = 1'b1;
      end_pos[pick]   = iv.live_end;
      r.physical_out  = pick;
    end else begin
      r.was_spilled = 1'b1;
      r.slot_out    = slot_next;
      if (slot_next != CNT_MAX) slot_next = slot_next + 1'b1;
      if (spill_cnt != CNT_MAX) spill_cnt = spill_cnt + 1'b1;
    end
    r.spill_total = spill_cnt;
    return r;
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      reg_count = REG_COUNT_DEFAULT;
      res_mask  = RES_MASK_DEFAULT;
      busy_map  = '0;
      slot_next = '0;
      spill_cnt = '0;
      grant_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_REG_COUNT: reg_count = cfg_wdata[REG_CNT_W-1:0];
          CFG_RES_MASK:  res_mask  = cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        n_checked++;
        if (out_data.was_spilled === 1'b1) n_spilled++;
        if (grant_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: result with no interval outstanding: vreg %h phys %0d", $time,
                     out_data.virtual_out, out_data.physical_out);
        end else begin
          want = grant_q.pop_front();
          if (out_data.virtual_out  !== want.virtual_out  ||
              out_data.physical_out !== want.physical_out ||
              out_data.was_spilled  !== want.was_spilled  ||
              out_data.slot_out     !== want.slot_out     ||
              out_data.spill_total  !== want.spill_total) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: expected vreg %h phys %0d spill %b slot %0d total %0d", $time,
                       want.virtual_out, want.physical_out, want.was_spilled,
                       want.slot_out, want.spill_total);
              $display("%0t:   actual vreg %h phys %0d spill %b slot %0d total %0d", $time,
                       out_data.virtual_out, out_data.physical_out, out_data.was_spilled,
                       out_data.slot_out, out_data.spill_total);
            end
          end
        end
      end
      if (in_valid && !in_stall) grant_q.push_back(allocate_interval(in_data));
    end
    fail_count <= n_bad;
    pending    <= grant_q.size();
    checked    <= n_checked;
    spilled    <= n_spilled;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lsra_pkg::*;

  localparam int HOLD_CYCLES   = 600;
  localparam int STUCK_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 205;
  localparam int SPILL_ITEMS   = 40;
  localparam int TAIL_CYCLES   = 50;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  int fail_count;
  int pending;
  int checked;
  int spilled;

  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  bit hold_req = 1'b0;
  int pos = 0;
  int run_left = 0;
  int sent_total = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  linear_scan_register_allocator #(.MAX_REGS(DEF_MAX_REGS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  allocation_checker #(.MAX_REGS(DEF_MAX_REGS)) grant_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .spilled    (spilled)
  );

  function automatic in_item_t mk(input logic nr, input logic [VID_W-1:0] vid,
                                  input logic [POS_W-1:0] st, input logic [POS_W-1:0] en);
    in_item_t iv;
    iv.new_run    = nr;
    iv.virtual_id = vid;
    iv.live_start = st;
    iv.live_end   = en;
    return iv;
  endfunction

  task automatic send_interval(input in_item_t iv);
    int gap;
    gap = quiet_tx ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= iv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly sorted runs with random content, some raw noise
  task automatic make_interval(input int span, output in_item_t iv);
    int st;
    int en;
    iv.new_run    = 1'b0;
    iv.virtual_id = VID_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      iv.new_run    = 1'($urandom);
      iv.live_start = POS_W'($urandom);
      iv.live_end   = POS_W'($urandom);
    end else begin
      if (run_left == 0) begin
        iv.new_run = 1'b1;
        pos        = int'($urandom_range(0, 65535));
        run_left   = int'($urandom_range(10, 80));
      end
      run_left--;
      pos = pos + int'($urandom_range(0, 3));
      if (pos > 65535) pos = 65535;
      st = pos;
      if ($urandom_range(0, 19) == 0) en = st - int'($urandom_range(1, 5));
      else en = st + int'($urandom_range(0, span));
      if (en < 0) en = 0;
      if (en > 65535) en = 65535;
      iv.live_start = POS_W'(st);
      iv.live_end   = POS_W'(en);
    end
  endtask

  // result side
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      n = quiet_rx ? 0 : int'($urandom_range(0, 8));
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    in_item_t             iv;
    int                   ph;
    int                   k;
    int                   span;
    logic [REG_CNT_W-1:0] cnt;
    logic [MASK_W-1:0]    mask;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // three usable registers (1..3), register 0 reserved
    cfg_write(CFG_REG_COUNT, CFG_DATA_W'(4));
    cfg_write(CFG_RES_MASK, CFG_DATA_W'(1));
    send_interval(mk(1'b1, 16'h0000, 16'h0000, 16'h0000));
    send_interval(mk(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_interval(mk(1'b0, 16'h0005, 16'h0000, 16'h000A));
    send_interval(mk(1'b0, 16'h0006, 16'h0000, 16'h0014));
    send_interval(mk(1'b0, 16'h0007, 16'h0001, 16'h001E));
    send_interval(mk(1'b0, 16'h0008, 16'h000B, 16'h0005));
    send_interval(mk(1'b0, 16'h0009, 16'h000B, 16'h0028));
    send_interval(mk(1'b0, 16'h000A, 16'h0005, 16'h0008));
    send_interval(mk(1'b0, 16'hAAAA, 16'hFFFF, 16'hFFFF));
    drain();
    // reserve everything while registers are still held
    cfg_write(CFG_RES_MASK, '1);
    send_interval(mk(1'b0, 16'h5555, 16'hFFFF, 16'h0000));
    drain();
    cfg_write(CFG_REG_COUNT, CFG_DATA_W'(0));
    cfg_write(CFG_RES_MASK, '0);
    send_interval(mk(1'b0, 16'h0001, 16'hFFFF, 16'hFFFF));
    drain();
    // count above the physical limit, only register 31 open
    cfg_write(CFG_REG_COUNT, CFG_DATA_W'(63));
    cfg_write(CFG_RES_MASK, CFG_DATA_W'(32'h7FFF_FFFF));
    send_interval(mk(1'b1, 16'h0002, 16'h0000, 16'hFFFF));
    send_interval(mk(1'b0, 16'h0003, 16'h0001, 16'h0002));
    drain();
    cfg_write(CFG_REG_COUNT, CFG_DATA_W'(33));
    cfg_write(CFG_RES_MASK, '0);
    send_interval(mk(1'b0, 16'h0004, 16'h8000, 16'h8001));
    send_interval(mk(1'b1, 16'h1234, 16'h7FFF, 16'h8000));
    drain();
    cfg_write(CFG_REG_COUNT, CFG_DATA_W'(1));
    send_interval(mk(1'b0, 16'h4321, 16'h8001, 16'h8001));
    send_interval(mk(1'b0, 16'h8765, 16'h8001, 16'h0000));
    drain();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin cnt = 6'd16; mask = 32'd48; span = 40; end
        1: begin cnt = 6'd32; mask = '0; span = 80; end
        2: begin cnt = 6'd1; mask = '0; span = 4; end
        3: begin
          cnt  = REG_CNT_W'($urandom_range(0, 63));
          mask = MASK_W'($urandom);
          span = int'($urandom_range(1, 100));
        end
        4: begin cnt = 6'd8; mask = '1; span = 10; end
        5: begin
          cnt  = REG_CNT_W'($urandom_range(2, 63));
          mask = MASK_W'($urandom & $urandom);
          span = 50;
        end
        default: begin cnt = 6'd63; mask = '0; span = 200; end
      endcase
      quiet_tx = (ph == 2) || (ph == 5);
      quiet_rx = (ph == 2) || (ph == 6);
      cfg_write(CFG_REG_COUNT, CFG_DATA_W'(cnt));
      cfg_write(CFG_RES_MASK, CFG_DATA_W'(mask));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 100) hold_req = 1'b1;
        make_interval(span, iv);
        send_interval(iv);
      end
      drain();
    end

    // no usable register: every interval spills, slots count up
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    cfg_write(CFG_REG_COUNT, CFG_DATA_W'(0));
    for (k = 0; k < SPILL_ITEMS; k++) begin
      iv.new_run    = (k == 0);
      iv.virtual_id = VID_W'($urandom);
      iv.live_start = POS_W'($urandom);
      iv.live_end   = POS_W'($urandom);
      send_interval(iv);
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("intervals sent: %0d (directed, seven register settings, all-spill run)",
             sent_total);
    $display("results checked: %0d, spilled: %0d, bad: %0d", checked, spilled, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
